// ----- hw/rtl/rca_pkg.sv -----
// ----------------------------------------------------------------------------
// rca_pkg
// Shared types and codes for the robust coordinate aggregator.
// ----------------------------------------------------------------------------
package rca_pkg;

    localparam int NUM_INPUTS = 8;

    typedef enum logic [1:0] {
        METHOD_MEAN   = 2'd0,
        METHOD_MEDIAN = 2'd1,
        METHOD_TRIM   = 2'd2
    } t_method;

    localparam logic [1:0] REG_METHOD       = 2'd0;
    localparam logic [1:0] REG_CLIENT_COUNT = 2'd1;
    localparam logic [1:0] REG_TRIM_COUNT   = 2'd2;

    // sideband through the sort and sum stages: averaged range [lo, hi)
    typedef struct packed {
        logic       valid;
        logic       err;
        logic [3:0] lo;
        logic [3:0] hi;
    } t_ctl;

    // sideband through the divider
    typedef struct packed {
        logic       valid;
        logic       err;
        logic       neg;
        logic [3:0] d;
    } t_dctl;

endpackage

// ----- hw/rtl/rca_sort_stage.sv -----
// ----------------------------------------------------------------------------
// rca_sort_stage
// One registered round of an odd-even transposition sort across the lanes.
// ----------------------------------------------------------------------------
module rca_sort_stage #(
    parameter int N     = 8,
    parameter int W     = 32,
    parameter int PHASE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rca_pkg::t_ctl        i_ctl,
    input  logic [N-1:0][W:0]    i_key,
    output rca_pkg::t_ctl        o_ctl,
    output logic [N-1:0][W:0]    o_key
);
    import rca_pkg::*;

    logic [N-1:0][W:0] n_key;
    t_ctl              r_ctl;
    logic [N-1:0][W:0] r_key;

    // compare-exchange neighbor pairs of this phase
    always_comb begin
        n_key = i_key;
        for (int i = PHASE; i + 1 < N; i += 2) begin
            if (i_key[i] > i_key[i+1]) begin
                n_key[i]   = i_key[i+1];
                n_key[i+1] = i_key[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_key <= n_key;
    end

    assign o_ctl = r_ctl;
    assign o_key = r_key;

endmodule

// ----- hw/rtl/rca_sum_tree.sv -----
// ----------------------------------------------------------------------------
// rca_sum_tree
// Masks the sorted lanes to the averaged range and sums them in three
// registered levels.
// ----------------------------------------------------------------------------
module rca_sum_tree #(
    parameter int N = 8,
    parameter int W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rca_pkg::t_ctl        i_ctl,
    input  logic [N-1:0][W:0]    i_key,
    output rca_pkg::t_ctl        o_ctl,
    output logic signed [W+2:0]  o_sum
);
    import rca_pkg::*;

    logic signed [W+2:0] n_term [NUM_INPUTS];
    logic signed [W+2:0] r_l1   [4];
    logic signed [W+2:0] r_l2   [2];
    logic signed [W+2:0] r_l3;
    t_ctl                r_ctl1, r_ctl2, r_ctl3;

    // drop lanes outside [lo, hi); undo the key's sign flip
    always_comb begin
        logic signed [W-1:0] v;
        for (int i = 0; i < NUM_INPUTS; i++) begin
            n_term[i] = '0;
        end
        for (int i = 0; i < N; i++) begin
            v = {~i_key[i][W-1], i_key[i][W-2:0]};
            if ((4'(i) >= i_ctl.lo) && (4'(i) < i_ctl.hi)) begin
                n_term[i] = (W+3)'(v);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
        end
        for (int j = 0; j < 4; j++) begin
            r_l1[j] <= n_term[2*j] + n_term[2*j+1];
        end
        r_l2[0] <= r_l1[0] + r_l1[1];
        r_l2[1] <= r_l1[2] + r_l1[3];
        r_l3    <= r_l2[0] + r_l2[1];
    end

    assign o_ctl = r_ctl3;
    assign o_sum = r_l3;

endmodule

// ----- hw/rtl/rca_div_stage.sv -----
// ----------------------------------------------------------------------------
// rca_div_stage
// One registered slice of a restoring divider: STEP quotient bits per stage,
// divisor of four bits, at most 15.
// ----------------------------------------------------------------------------
module rca_div_stage #(
    parameter int DP   = 36,
    parameter int STEP = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rca_pkg::t_dctl   i_ctl,
    input  logic [DP-1:0]    i_num,
    input  logic [DP-1:0]    i_quo,
    input  logic [3:0]       i_rem,
    output rca_pkg::t_dctl   o_ctl,
    output logic [DP-1:0]    o_num,
    output logic [DP-1:0]    o_quo,
    output logic [3:0]       o_rem
);
    import rca_pkg::*;

    logic [DP-1:0] n_num, n_quo;
    logic [3:0]    n_rem;
    t_dctl         r_ctl;
    logic [DP-1:0] r_num, r_quo;
    logic [3:0]    r_rem;

    always_comb begin
        logic [4:0] t;
        logic       ge;
        n_num = i_num;
        n_quo = i_quo;
        n_rem = i_rem;
        for (int s = 0; s < STEP; s++) begin
            t     = {n_rem, n_num[DP-1]};
            ge    = (t >= {1'b0, i_ctl.d});
            n_num = {n_num[DP-2:0], 1'b0};
            n_quo = {n_quo[DP-2:0], ge};
            n_rem = ge ? 4'(t - {1'b0, i_ctl.d}) : t[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_ctl = r_ctl;
    assign o_num = r_num;
    assign o_quo = r_quo;
    assign o_rem = r_rem;

endmodule

// ----- hw/rtl/robust_coordinate_aggregator.sv -----
// ----------------------------------------------------------------------------
// robust_coordinate_aggregator
// Coordinate-wise mean, median or trimmed mean over up to eight clients.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with weight_0..weight_7 on the inputs; the request is taken
//   whenever start is high, since busy stays low (the block is a pipeline).
//   One request may follow another in every cycle: one coordinate per cycle.
//   Each request yields one result, shown for one cycle with o_valid high.
//   Requests pass the entry register, the transposition sorter (one round per
//   lane count), the sum tree, the magnitude register, the 4-bit-per-stage
//   divider and the output register. Configuration (method, client count,
//   trim count) is written through i_cfg_we / i_cfg_idx / i_cfg_data, by the
//   user only while no request is in flight; the block does not enforce it.
//   Reset clears the pipeline valids and loads method mean, count 8, trim 1.
//   The receiver cannot stall: results leave on the strobe cycle.
//   o_config_error flags a trimmed-mean request with too few clients; the
//   aggregate is then zero.
// ----------------------------------------------------------------------------
module robust_coordinate_aggregator #(
    parameter int MAX_CLIENTS = 8,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [WEIGHT_BITS-1:0] i_weight_0,
    input  logic signed [WEIGHT_BITS-1:0] i_weight_1,
    input  logic signed [WEIGHT_BITS-1:0] i_weight_2,
    input  logic signed [WEIGHT_BITS-1:0] i_weight_3,
    input  logic signed [WEIGHT_BITS-1:0] i_weight_4,
    input  logic signed [WEIGHT_BITS-1:0] i_weight_5,
    input  logic signed [WEIGHT_BITS-1:0] i_weight_6,
    input  logic signed [WEIGHT_BITS-1:0] i_weight_7,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [3:0]                    i_cfg_data,
    output logic                          o_valid,
    output logic signed [WEIGHT_BITS-1:0] o_aggregate,
    output logic                          o_config_error
);
    import rca_pkg::*;

    localparam int N          = MAX_CLIENTS;
    localparam int W          = WEIGHT_BITS;
    localparam int DW         = W + 3;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (DW + DIV_STEP - 1) / DIV_STEP;
    localparam int DP         = DIV_STAGES * DIV_STEP;

    // configuration registers
    logic [1:0] r_method;
    logic [3:0] r_client_count;
    logic [1:0] r_trim_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method       <= METHOD_MEAN;
            r_client_count <= 4'd8;
            r_trim_count   <= 2'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_METHOD:       r_method       <= i_cfg_data[1:0];
                REG_CLIENT_COUNT: r_client_count <= i_cfg_data;
                REG_TRIM_COUNT:   r_trim_count   <= i_cfg_data[1:0];
                default:          ;   // unmapped index: drop the write
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- entry stage: clamp count, pick range, build keys -----
    logic signed [W-1:0] w_in [NUM_INPUTS];
    assign w_in[0] = i_weight_0;
    assign w_in[1] = i_weight_1;
    assign w_in[2] = i_weight_2;
    assign w_in[3] = i_weight_3;
    assign w_in[4] = i_weight_4;
    assign w_in[5] = i_weight_5;
    assign w_in[6] = i_weight_6;
    assign w_in[7] = i_weight_7;

    t_ctl              n_ctl0, r_ctl0;
    logic [N-1:0][W:0] n_key0, r_key0;

    always_comb begin
        logic [3:0] cnt;
        logic [3:0] half;
        cnt = r_client_count;
        if (cnt == 4'd0) begin
            cnt = 4'd1;
        end else if (cnt > 4'(N)) begin
            cnt = 4'(N);
        end
        half         = cnt >> 1;
        n_ctl0.valid = start;
        n_ctl0.err   = 1'b0;
        n_ctl0.lo    = 4'd0;
        n_ctl0.hi    = cnt;
        unique case (r_method)
            METHOD_MEDIAN: begin
                // even count: average the two middle values
                n_ctl0.lo = cnt[0] ? half : half - 4'd1;
                n_ctl0.hi = half + 4'd1;
            end
            METHOD_TRIM: begin
                if ({1'b0, cnt} <= {2'b00, r_trim_count, 1'b0}) begin
                    n_ctl0.err = 1'b1;
                    n_ctl0.hi  = 4'd1;
                end else begin
                    n_ctl0.lo = {2'b00, r_trim_count};
                    n_ctl0.hi = cnt - {2'b00, r_trim_count};
                end
            end
            default: ;   // mean, also for the unused code
        endcase
        // key: inactive flag on top, sign flipped for an unsigned compare
        for (int i = 0; i < N; i++) begin
            n_key0[i] = {~(4'(i) < cnt), ~w_in[i][W-1], w_in[i][W-2:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else begin
            r_ctl0 <= n_ctl0;
        end
        r_key0 <= n_key0;
    end

    // ---------------- sort lanes: N transposition rounds -------------------
    t_ctl              w_sctl [N+1];
    logic [N-1:0][W:0] w_skey [N+1];
    assign w_sctl[0] = r_ctl0;
    assign w_skey[0] = r_key0;

    for (genvar r = 0; r < N; r++) begin : g_sort
        rca_sort_stage #(.N(N), .W(W), .PHASE(r % 2)) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_sctl[r]),
            .i_key   (w_skey[r]),
            .o_ctl   (w_sctl[r+1]),
            .o_key   (w_skey[r+1])
        );
    end

    // ---------------- merge: masked sum of the selected lanes --------------
    t_ctl                w_tctl;
    logic signed [DW-1:0] w_sum;

    rca_sum_tree #(.N(N), .W(W)) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sctl[N]),
        .i_key   (w_skey[N]),
        .o_ctl   (w_tctl),
        .o_sum   (w_sum)
    );

    // ---------------- magnitude and divisor --------------------------------
    t_dctl         r_pctl;
    logic [DP-1:0] r_pnum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pctl <= '0;
        end else begin
            r_pctl.valid <= w_tctl.valid;
            r_pctl.err   <= w_tctl.err;
            r_pctl.neg   <= w_sum[DW-1];
            r_pctl.d     <= w_tctl.hi - w_tctl.lo;
        end
        // magnitude is unsigned: the most negative sum maps to its top bit only
        r_pnum <= DP'($unsigned(w_sum[DW-1] ? -w_sum : w_sum));
    end

    // ---------------- divide: truncating, on the magnitude -----------------
    t_dctl         w_dctl [DIV_STAGES+1];
    logic [DP-1:0] w_num  [DIV_STAGES+1];
    logic [DP-1:0] w_quo  [DIV_STAGES+1];
    logic [3:0]    w_rem  [DIV_STAGES+1];
    assign w_dctl[0] = r_pctl;
    assign w_num[0]  = r_pnum;
    assign w_quo[0]  = '0;
    assign w_rem[0]  = '0;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        rca_div_stage #(.DP(DP), .STEP(DIV_STEP)) u_slice (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_dctl[s]),
            .i_num   (w_num[s]),
            .i_quo   (w_quo[s]),
            .i_rem   (w_rem[s]),
            .o_ctl   (w_dctl[s+1]),
            .o_num   (w_num[s+1]),
            .o_quo   (w_quo[s+1]),
            .o_rem   (w_rem[s+1])
        );
    end

    // ---------------- output register: restore sign, force zero on error ---
    t_dctl         w_fctl;
    logic [W-1:0]  w_q;
    assign w_fctl = w_dctl[DIV_STAGES];
    assign w_q    = w_quo[DIV_STAGES][W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid        <= 1'b0;
            o_config_error <= 1'b0;
        end else begin
            o_valid        <= w_fctl.valid;
            o_config_error <= w_fctl.valid & w_fctl.err;
        end
        if (w_fctl.err) begin
            o_aggregate <= '0;
        end else begin
            o_aggregate <= w_fctl.neg ? -w_q : w_q;
        end
    end

    // ---------------- assertions -------------------------------------------
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_config_error |-> (o_valid && o_aggregate == '0))
        else $error("config error without a zero result");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pctl.valid |-> (r_pctl.d != 4'd0 && r_pctl.d <= 4'(N)))
        else $error("divisor out of range");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl0.valid && r_ctl0.err) |-> (r_ctl0.lo == 4'd0 && r_ctl0.hi == 4'd1))
        else $error("error request carries a live range");

    for (genvar i = 0; i + 1 < N; i++) begin : g_chk
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_sctl[N].valid |-> (w_skey[N][i] <= w_skey[N][i+1]))
            else $error("sorter output out of order");
    end

endmodule

// ----- dv/tb_robust_coordinate_aggregator.sv -----
// ----------------------------------------------------------------------------
// tb_robust_coordinate_aggregator
// Self-checking bench for the robust coordinate aggregator: a directed table
// of corner requests, then random requests over many register settings, all
// checked field by field against a typed answer or a behavioral aggregate predictor.
// ----------------------------------------------------------------------------
module tb_robust_coordinate_aggregator;
    timeunit 1ns;
    timeprecision 1ps;

    import rca_pkg::*;

    localparam int                 NCLI   = 8;
    localparam logic signed [31:0] W_MAX  = 32'sh7fff_ffff;
    localparam logic signed [31:0] W_MIN  = 32'sh8000_0000;
    localparam int                 N_RAND = 1330;

    typedef logic signed [31:0] t_wvec [NCLI];

    // one expected result
    typedef struct {
        logic signed [31:0] agg;
        logic               err;
    } t_agg_exp;

    // one row of the directed table: register values, request, optional answer
    typedef struct {
        logic [3:0]         m;
        logic [3:0]         c;
        logic [3:0]         t;
        t_wvec              w;
        bit                 typed;
        logic signed [31:0] agg;
        logic               err;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] i_weight [NCLI];
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [3:0]         i_cfg_data = '0;
    logic               o_valid;
    logic signed [31:0] o_aggregate;
    logic               o_config_error;

    // register mirror, as written (4-bit data, masked where used)
    logic [3:0] cfg_method = 4'd0;
    logic [3:0] cfg_count  = 4'd8;
    logic [3:0] cfg_trim   = 4'd1;

    t_agg_exp aggregates_due[$];
    t_row     corner_rows[$];
    int       n_fail = 0;
    int       n_results = 0;
    int       n_errs_seen = 0;
    int       burst_left = 0;

    initial begin
        for (int k = 0; k < NCLI; k++) i_weight[k] = '0;
    end

    always #4 i_clk = ~i_clk;

    robust_coordinate_aggregator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_weight_0     (i_weight[0]),
        .i_weight_1     (i_weight[1]),
        .i_weight_2     (i_weight[2]),
        .i_weight_3     (i_weight[3]),
        .i_weight_4     (i_weight[4]),
        .i_weight_5     (i_weight[5]),
        .i_weight_6     (i_weight[6]),
        .i_weight_7     (i_weight[7]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_aggregate    (o_aggregate),
        .o_config_error (o_config_error)
    );

    // Aggregate predictor: clamp the count, sort for the order-statistic
    // methods, then take the truncating mean of the kept range [lo, hi).
    function automatic t_agg_exp predict_aggregate(t_wvec w, logic [3:0] m_raw,
                                                   logic [3:0] c_raw, logic [3:0] t_raw);
        t_agg_exp           r;
        logic [1:0]         meth;
        int                 n;
        int                 trim;
        int                 lo;
        int                 hi;
        longint             sum;
        logic signed [31:0] s [NCLI];
        logic signed [31:0] tmp;
        meth = m_raw[1:0];
        trim = t_raw[1:0];
        n = (c_raw == 0) ? 1 : (c_raw > NCLI) ? NCLI : c_raw;
        s = w;
        r.err = 1'b0;
        r.agg = '0;
        if (meth == METHOD_MEDIAN || meth == METHOD_TRIM) begin
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n - 1 - i; j++)
                    if (s[j] > s[j+1]) begin
                        tmp = s[j]; s[j] = s[j+1]; s[j+1] = tmp;
                    end
        end
        if (meth == METHOD_MEDIAN) begin
            lo = (n % 2 == 0) ? n / 2 - 1 : n / 2;
            hi = (n % 2 == 0) ? n / 2 + 1 : n / 2 + 1;
        end else if (meth == METHOD_TRIM) begin
            lo = trim;
            hi = n - trim;
            if (n <= 2 * trim) begin
                r.err = 1'b1;
                return r;
            end
        end else begin
            lo = 0;
            hi = n;
        end
        sum = 0;
        for (int i = lo; i < hi; i++) sum += longint'(s[i]);
        r.agg = 32'(sum / longint'(hi - lo));    // signed divide truncates toward zero
        return r;
    endfunction

    // Write all three registers plus a write to the unused index, which must
    // be ignored. Call only with nothing in flight.
    task automatic write_regs(logic [3:0] m, logic [3:0] c, logic [3:0] t);
        logic [3:0] vals [4];
        vals = '{m, c, t, 4'($urandom_range(0, 15))};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 2'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_method = m;
        cfg_count  = c;
        cfg_trim   = t;
    endtask

    // Let the pipeline empty before touching the registers.
    task automatic drain_pipe();
        while (aggregates_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Issue one request in the burst/gap pattern; hold start until accepted.
    // Returns positioned at the accepting edge, start still high.
    task automatic send_request(t_wvec w, bit typed, logic signed [31:0] agg, logic err);
        int       gap;
        t_agg_exp e;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        start <= 1'b1;
        for (int k = 0; k < NCLI; k++) i_weight[k] <= w[k];
        do @(posedge i_clk); while (busy);
        if (typed) begin
            e.agg = agg;
            e.err = err;
        end else begin
            e = predict_aggregate(w, cfg_method, cfg_count, cfg_trim);
        end
        aggregates_due.push_back(e);
    endtask

    // Close out the current burst so no request is pending across a write.
    task automatic end_burst();
        start <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
    endtask

    // Weight generator: corners, small values, values near the corners and full random.
    function automatic logic signed [31:0] pick_weight();
        case ($urandom_range(0, 7))
            0:       return W_MAX;
            1:       return W_MIN;
            2:       return 32'($signed($urandom_range(0, 64)) - 32);
            3:       return W_MAX - 32'($urandom_range(0, 15));
            4:       return W_MIN + 32'($urandom_range(0, 15));
            default: return $urandom();
        endcase
    endfunction

    task automatic add_row(logic [3:0] m, logic [3:0] c, logic [3:0] t, t_wvec w,
                           bit typed, logic signed [31:0] agg, logic err);
        t_row r;
        r = '{m, c, t, w, typed, agg, err};
        corner_rows.push_back(r);
    endtask

    // Compare every strobed result with the oldest expectation.
    always @(posedge i_clk) begin
        t_agg_exp e;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (aggregates_due.size() == 0) begin
                $error("result with nothing expected: aggregate %0d config_error %0b",
                       o_aggregate, o_config_error);
                n_fail++;
            end else begin
                e = aggregates_due.pop_front();
                if (o_aggregate !== e.agg) begin
                    $error("aggregate: expected %0d actual %0d", e.agg, o_aggregate);
                    n_fail++;
                end
                if (o_config_error !== e.err) begin
                    $error("config_error: expected %0b actual %0b", e.err, o_config_error);
                    n_fail++;
                end
                if (e.err) n_errs_seen++;
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_wvec      w;
        logic [3:0] pm [6];
        logic [3:0] pc [6];
        logic [3:0] pt [6];
        int         per_phase;
        int         sent;

        // Directed table. Typed answers only where obvious.
        add_row(4'd0, 4'd8, 4'd1, '{default: 32'sd0}, 1, 32'sd0, 1'b0);        // reset values
        add_row(4'd0, 4'd8, 4'd1, '{default: W_MAX}, 1, W_MAX, 1'b0);           // sum of maxima
        add_row(4'd0, 4'd8, 4'd1, '{default: W_MIN}, 1, W_MIN, 1'b0);           // sum of minima
        add_row(4'd0, 4'd8, 4'd1, '{W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN},
                0, 0, 0);
        add_row(4'd0, 4'd1, 4'd0, '{5, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX},
                1, 32'sd5, 1'b0);                                                // client 0 only
        add_row(4'd0, 4'd3, 4'd0, '{-1, -1, 1, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX},
                1, 32'sd0, 1'b0);                                                // truncate to zero
        add_row(4'd1, 4'd1, 4'd0, '{-7, 3, 3, 3, 3, 3, 3, 3}, 1, -32'sd7, 1'b0);
        add_row(4'd1, 4'd2, 4'd0, '{-3, 2, 0, 0, 0, 0, 0, 0}, 1, 32'sd0, 1'b0); // even median
        add_row(4'd1, 4'd8, 4'd0, '{9, -4, W_MAX, 7, W_MIN, 0, 7, -4}, 0, 0, 0);
        add_row(4'd1, 4'd7, 4'd0, '{W_MIN, 3, 3, W_MAX, -2, 100, 5, 0}, 0, 0, 0);
        add_row(4'd1, 4'd8, 4'd0, '{W_MAX, W_MAX, W_MAX, W_MAX, W_MAX - 1, W_MAX, 0, 1},
                0, 0, 0);
        add_row(4'd2, 4'd2, 4'd1, '{1, 2, 3, 4, 5, 6, 7, 8}, 1, 32'sd0, 1'b1); // too few
        add_row(4'd2, 4'd6, 4'd3, '{1, 2, 3, 4, 5, 6, 7, 8}, 1, 32'sd0, 1'b1); // too few
        add_row(4'd2, 4'd1, 4'd0, '{-9, 2, 3, 4, 5, 6, 7, 8}, 1, -32'sd9, 1'b0);
        add_row(4'd2, 4'd7, 4'd3, '{W_MAX, -5, 8, W_MIN, 2, 2, 40, 0}, 0, 0, 0);
        add_row(4'd2, 4'd8, 4'd0, '{W_MAX, W_MAX, W_MIN, -1, 2, 3, W_MAX, 6}, 0, 0, 0);
        add_row(4'd2, 4'd8, 4'd3, '{W_MIN, W_MAX, 10, -10, 11, -11, 0, 4}, 0, 0, 0);
        add_row(4'd3, 4'd8, 4'd2, '{-1, -2, -3, -4, -5, -6, -7, 4}, 0, 0, 0);  // method 3 is mean
        add_row(4'd0, 4'd0, 4'd0, '{-12, 1, 1, 1, 1, 1, 1, 1}, 1, -32'sd12, 1'b0); // count 0
        add_row(4'd0, 4'd15, 4'd0, '{W_MAX, W_MAX, 1, 2, 3, W_MIN, 4, 5}, 0, 0, 0); // count 15
        add_row(4'd1, 4'd9, 4'd0, '{0, 1, 2, 3, 4, 5, 6, 7}, 0, 0, 0);
        add_row(4'd14, 4'd8, 4'd13, '{3, 1, 4, 1, 5, 9, 2, 6}, 0, 0, 0);       // masked data

        // Hold reset, then release on a clock edge.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_rows[r]) begin
            if (corner_rows[r].m != cfg_method || corner_rows[r].c != cfg_count
                || corner_rows[r].t != cfg_trim) begin
                end_burst();
                drain_pipe();
                write_regs(corner_rows[r].m, corner_rows[r].c, corner_rows[r].t);
            end
            send_request(corner_rows[r].w, corner_rows[r].typed,
                         corner_rows[r].agg, corner_rows[r].err);
        end

        // Random phases: the extremes first, then random register settings.
        pm = '{4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2};
        pc = '{4'd8, 4'd8, 4'd1, 4'd8, 4'd7, 4'd1};
        pt = '{4'd0, 4'd0, 4'd0, 4'd3, 4'd3, 4'd0};
        per_phase = 85;
        sent = 0;
        for (int ph = 0; sent < N_RAND; ph++) begin
            end_burst();
            drain_pipe();
            if (ph < 6)
                write_regs(pm[ph], pc[ph], pt[ph]);
            else
                write_regs(4'($urandom_range(0, 15)),
                           ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                                       : 4'($urandom_range(1, 8)),
                           4'($urandom_range(0, 15)));
            for (int i = 0; i < per_phase && sent < N_RAND; i++) begin
                for (int k = 0; k < NCLI; k++) w[k] = pick_weight();
                // duplicates exercise ties in the sorter
                if ($urandom_range(0, 3) == 0) w[$urandom_range(0, 7)] = w[$urandom_range(0, 7)];
                send_request(w, 0, 0, 0);
                sent++;
            end
        end

        end_burst();
        drain_pipe();
        repeat (30) @(posedge i_clk);

        $display("Covered %0d requests over mean, median and trimmed modes and many counts;",
                 corner_rows.size() + N_RAND);
        $display("  %0d results checked, %0d of them flagged as too few to trim.",
                 n_results, n_errs_seen);
        if (n_fail == 0 && aggregates_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (aggregates_due.size() != 0)
                $error("%0d expected results never arrived", aggregates_due.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
